// File: hw/rtl/sgp_pkg.sv
// Shared types, constants and fixed-point helpers for skeleton_global_pose.
// No dependencies; compiled first.
`default_nettype none

package sgp_pkg;

  localparam int MAX_JOINTS_DEF = 256;
  localparam int ROW_WORDS      = 12;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  typedef struct packed {
    logic [7:0]         joint_index;
    logic [7:0]         parent_index;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] uniform_scale;
  } sgp_in_t;

  typedef struct packed {
    logic [7:0]         out_joint;
    logic [1:0]         row_number;
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic               last_row;
  } sgp_out_t;

  typedef enum logic [1:0] {
    KIND_QUAT,
    KIND_SCALE,
    KIND_MAC
  } kind_e;

  // Tag that follows one multiply through the pipeline.
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [3:0] dst;
    logic       first;
    logic       last;
  } op_tag_t;

  // Clamp a 35-bit exact sum to Q16.16 range.
  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -35'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Round a Q32.32 product to nearest Q16.16 (ties up), then clamp.
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic signed [47:0] q;
    logic signed [31:0] r;
    s = p + 64'sd32768;
    q = s[63:16];
    if (q > 48'sd2147483647) r = 32'sh7FFFFFFF;
    else if (q < -48'sd2147483648) r = 32'sh80000000;
    else r = q[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sgp_if.sv
// Valid/ready channel interfaces for joint items and matrix rows.
// Depends on sgp_pkg for the payload types.
`default_nettype none

interface sgp_in_if import sgp_pkg::*; ();
  logic    valid;
  logic    ready;
  sgp_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sgp_out_if import sgp_pkg::*; ();
  logic     valid;
  logic     ready;
  sgp_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sgp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sgp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 3072,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/sgp_mul.sv
// Shared signed 32x32 multiplier with registered product and Q16.16 rounding.
// Depends on sgp_pkg for qround.
`default_nettype none

module sgp_mul import sgp_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] r_o
);

  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign r_o = qround(prod_q);

endmodule

`default_nettype wire

// File: hw/rtl/skeleton_global_pose.sv
// Skeleton global pose: one joint per input transaction, four matrix-row
// transactions out. Depends on sgp_pkg, sgp_if, sgp_mul and sgp_ram.
//
// Each joint builds its local 4x3 affine matrix (scaled quaternion rotation,
// translation in row 3) and, unless it is a root (parent_index equal to
// joint_index), multiplies it by its parent's stored global matrix. All
// products run on one shared 32x32 multiplier: 9 quaternion products,
// 9 scale products and, for a child joint, 39 matrix products, one issued
// per cycle with a drain between dependent phases. The four rows leave
// one per cycle while out_o.ready is high. The input is not ready until
// the last row of the joint has gone out. Parents must be
// sent before their children; the global store holds no valid bits and a
// parent that was never written reads as garbage. Joints map to store
// slots modulo MAX_JOINTS.
`default_nettype none

module skeleton_global_pose import sgp_pkg::*; #(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sgp_in_if.sink    in_i,
  sgp_out_if.source out_o
);

  localparam int Depth = MAX_JOINTS * ROW_WORDS;
  localparam int AW    = $clog2(Depth);
  localparam int SlotW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_QUAT   = 3'd1;
  localparam logic [2:0] S_SCALE  = 3'd2;
  localparam logic [2:0] S_MAC    = 3'd3;
  localparam logic [2:0] S_MDRAIN = 3'd4;
  localparam logic [2:0] S_COPY   = 3'd5;
  localparam logic [2:0] S_STORE  = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  // Index of each quaternion product in qp_q
  localparam logic [3:0] QP_XX = 4'd0;
  localparam logic [3:0] QP_YY = 4'd1;
  localparam logic [3:0] QP_ZZ = 4'd2;
  localparam logic [3:0] QP_XY = 4'd3;
  localparam logic [3:0] QP_XZ = 4'd4;
  localparam logic [3:0] QP_YZ = 4'd5;
  localparam logic [3:0] QP_XW = 4'd6;
  localparam logic [3:0] QP_YW = 4'd7;
  localparam logic [3:0] QP_ZW = 4'd8;

  localparam logic [3:0] PHASE_LAST = 4'd10;  // 9 issues, then the drain
  localparam logic [3:0] PHASE_ISS  = 4'd9;

  // Joint index to store slot, worked out at elaboration
  logic [SlotW-1:0] slot_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_slot
    assign slot_tab[g] = SlotW'(g % MAX_JOINTS);
  end

  logic [2:0]        state_q, state_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [1:0]        i_q, i_d, j_q, j_d, k_q, k_d;
  logic [1:0]        row_q, row_d;
  sgp_in_t           item_q;
  logic [SlotW-1:0]  jslot_q, pslot_q;
  logic              root_q;

  logic signed [31:0] qp_q  [9];
  logic signed [31:0] loc_q [9];
  logic signed [31:0] glb_q [12];
  logic signed [34:0] acc_q;

  // Pipeline: stage 0 holds operands, stage 1 holds the product
  op_tag_t            tag0_q, tag0_d, tag1_q;
  logic signed [31:0] a0_q, a0_d, b0_q, b0_d;
  logic signed [31:0] mul_b, mul_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic [AW-1:0] jbase, pbase;

  logic signed [31:0] rot_elem;
  logic signed [34:0] acc_next;
  logic [3:0]         loc_idx, mac_off, mac_dst, out_base;
  logic               mac_last;

  assign in_i.ready = (state_q == S_IDLE);

  assign jbase = (AW'(jslot_q) << 3) + (AW'(jslot_q) << 2);
  assign pbase = (AW'(pslot_q) << 3) + (AW'(pslot_q) << 2);

  assign loc_idx  = 4'({i_q, 1'b0}) + 4'(i_q) + 4'(k_q);
  assign mac_off  = 4'({k_q, 1'b0}) + 4'(k_q) + 4'(j_q);
  assign mac_dst  = 4'({i_q, 1'b0}) + 4'(i_q) + 4'(j_q);
  assign mac_last = (i_q == 2'd3) ? (k_q == 2'd3) : (k_q == 2'd2);

  // Rotation element cnt_q, row-major: const + (+-2A) + (+-2B), then clamp
  always_comb begin
    logic signed [31:0] ta, tb;
    logic               na, nb, one;
    logic signed [34:0] sa, sb, sum;
    ta  = qp_q[QP_YY];
    tb  = qp_q[QP_ZZ];
    na  = 1'b1;
    nb  = 1'b1;
    one = 1'b1;
    case (cnt_q)
      4'd0: begin ta = qp_q[QP_YY]; tb = qp_q[QP_ZZ]; na = 1'b1; nb = 1'b1; one = 1'b1; end
      4'd1: begin ta = qp_q[QP_XY]; tb = qp_q[QP_ZW]; na = 1'b0; nb = 1'b0; one = 1'b0; end
      4'd2: begin ta = qp_q[QP_XZ]; tb = qp_q[QP_YW]; na = 1'b0; nb = 1'b1; one = 1'b0; end
      4'd3: begin ta = qp_q[QP_XY]; tb = qp_q[QP_ZW]; na = 1'b0; nb = 1'b1; one = 1'b0; end
      4'd4: begin ta = qp_q[QP_XX]; tb = qp_q[QP_ZZ]; na = 1'b1; nb = 1'b1; one = 1'b1; end
      4'd5: begin ta = qp_q[QP_YZ]; tb = qp_q[QP_XW]; na = 1'b0; nb = 1'b0; one = 1'b0; end
      4'd6: begin ta = qp_q[QP_XZ]; tb = qp_q[QP_YW]; na = 1'b0; nb = 1'b0; one = 1'b0; end
      4'd7: begin ta = qp_q[QP_YZ]; tb = qp_q[QP_XW]; na = 1'b0; nb = 1'b1; one = 1'b0; end
      4'd8: begin ta = qp_q[QP_XX]; tb = qp_q[QP_YY]; na = 1'b1; nb = 1'b1; one = 1'b1; end
      default: begin ta = qp_q[QP_XX]; tb = qp_q[QP_YY]; na = 1'b1; nb = 1'b1; one = 1'b1; end
    endcase
    sa  = 35'(ta) <<< 1;
    sb  = 35'(tb) <<< 1;
    sum = (one ? 35'(Q_ONE) : 35'sd0) + (na ? -sa : sa) + (nb ? -sb : sb);
    rot_elem = sat35(sum);
  end

  // Sequencer: issues one multiply per cycle in its issue phases and walks the phases
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    row_d     = row_q;
    tag0_d    = '0;
    tag0_d.kind = KIND_QUAT;
    a0_d      = a0_q;
    b0_d      = b0_q;
    ram_raddr = pbase + AW'(mac_off);
    ram_we    = 1'b0;
    ram_waddr = jbase + AW'(cnt_q);
    ram_wdata = glb_q[cnt_q];
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_QUAT;
          cnt_d   = 4'd0;
        end
      end
      S_QUAT: begin
        if (cnt_q < PHASE_ISS) begin
          tag0_d.valid = 1'b1;
          tag0_d.kind  = KIND_QUAT;
          tag0_d.dst   = cnt_q;
        end
        case (cnt_q)
          QP_XX: begin a0_d = item_q.quat_x; b0_d = item_q.quat_x; end
          QP_YY: begin a0_d = item_q.quat_y; b0_d = item_q.quat_y; end
          QP_ZZ: begin a0_d = item_q.quat_z; b0_d = item_q.quat_z; end
          QP_XY: begin a0_d = item_q.quat_x; b0_d = item_q.quat_y; end
          QP_XZ: begin a0_d = item_q.quat_x; b0_d = item_q.quat_z; end
          QP_YZ: begin a0_d = item_q.quat_y; b0_d = item_q.quat_z; end
          QP_XW: begin a0_d = item_q.quat_x; b0_d = item_q.quat_w; end
          QP_YW: begin a0_d = item_q.quat_y; b0_d = item_q.quat_w; end
          QP_ZW: begin a0_d = item_q.quat_z; b0_d = item_q.quat_w; end
          default: ;
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == PHASE_LAST) begin
          state_d = S_SCALE;
          cnt_d   = 4'd0;
        end
      end
      S_SCALE: begin
        if (cnt_q < PHASE_ISS) begin
          tag0_d.valid = 1'b1;
          tag0_d.kind  = KIND_SCALE;
          tag0_d.dst   = cnt_q;
        end
        a0_d  = rot_elem;
        b0_d  = item_q.uniform_scale;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == PHASE_LAST) begin
          state_d = root_q ? S_COPY : S_MAC;
          cnt_d   = 4'd0;
          i_d     = 2'd0;
          j_d     = 2'd0;
          k_d     = 2'd0;
        end
      end
      S_MAC: begin
        // Parent word (k, j) is read now and meets its operand next cycle
        tag0_d.valid = 1'b1;
        tag0_d.kind  = KIND_MAC;
        tag0_d.dst   = mac_dst;
        tag0_d.first = (k_q == 2'd0);
        tag0_d.last  = mac_last;
        if (i_q == 2'd3) begin
          case (k_q)
            2'd0:    a0_d = item_q.trans_x;
            2'd1:    a0_d = item_q.trans_y;
            2'd2:    a0_d = item_q.trans_z;
            default: a0_d = Q_ONE;  // parent row 3 passes through exactly
          endcase
        end else begin
          a0_d = loc_q[loc_idx];
        end
        if (mac_last) begin
          k_d = 2'd0;
          if (j_q == 2'd2) begin
            j_d = 2'd0;
            if (i_q == 2'd3) begin
              state_d = S_MDRAIN;
              cnt_d   = 4'd0;
            end else begin
              i_d = i_q + 2'd1;
            end
          end else begin
            j_d = j_q + 2'd1;
          end
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_MDRAIN: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd1) begin
          state_d = S_STORE;
          cnt_d   = 4'd0;
        end
      end
      S_COPY: begin
        state_d = S_STORE;
        cnt_d   = 4'd0;
      end
      S_STORE: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'(ROW_WORDS - 1)) begin
          state_d = S_EMIT;
          row_d   = 2'd0;
        end
      end
      S_EMIT: begin
        if (out_o.ready) begin
          row_d = row_q + 2'd1;
          if (row_q == 2'd3) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      row_q   <= '0;
      tag0_q  <= '0;
      tag1_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      row_q   <= row_d;
      tag0_q  <= tag0_d;
      tag1_q  <= tag0_q;
    end
  end

  // Capture the joint and resolve its slots on acceptance
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q  <= in_i.data;
      jslot_q <= slot_tab[in_i.data.joint_index];
      pslot_q <= slot_tab[in_i.data.parent_index];
      root_q  <= (in_i.data.joint_index == in_i.data.parent_index);
    end
    a0_q <= a0_d;
    b0_q <= b0_d;
  end

  assign mul_b = (tag0_q.kind == KIND_MAC) ? ram_rdata : b0_q;

  sgp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (a0_q),
    .b_i   (mul_b),
    .r_o   (mul_r)
  );

  assign acc_next = (tag1_q.first ? 35'sd0 : acc_q) + 35'(mul_r);

  // Write back rounded products; the global rows stay put until the next joint
  always_ff @(posedge clk_i) begin
    if (tag1_q.valid) begin
      case (tag1_q.kind)
        KIND_QUAT:  qp_q[tag1_q.dst]  <= mul_r;
        KIND_SCALE: loc_q[tag1_q.dst] <= mul_r;
        KIND_MAC: begin
          acc_q <= acc_next;
          if (tag1_q.last) begin
            glb_q[tag1_q.dst] <= sat35(acc_next);
          end
        end
        default: ;
      endcase
    end
    if (state_q == S_COPY) begin
      for (int n = 0; n < 9; n++) begin
        glb_q[n] <= loc_q[n];
      end
      glb_q[9]  <= item_q.trans_x;
      glb_q[10] <= item_q.trans_y;
      glb_q[11] <= item_q.trans_z;
    end
  end

  sgp_ram #(
    .WIDTH (32),
    .DEPTH (Depth),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result rows come straight from the held global matrix
  assign out_base = 4'({row_q, 1'b0}) + 4'(row_q);
  assign out_o.valid           = (state_q == S_EMIT);
  assign out_o.data.out_joint  = item_q.joint_index;
  assign out_o.data.row_number = row_q;
  assign out_o.data.elem_0     = glb_q[out_base];
  assign out_o.data.elem_1     = glb_q[out_base + 4'd1];
  assign out_o.data.elem_2     = glb_q[out_base + 4'd2];
  assign out_o.data.last_row   = (row_q == 2'd3);

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_QUAT && cnt_q == 4'd0))
    else $error("accepted transaction did not start the quaternion phase");

  a_last_row_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.data.last_row) |=> in_i.ready)
    else $error("block not ready after the last row transaction");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while rows are pending");

  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !tag1_q.valid)
    else $error("store written while a product is still in flight");
`endif

endmodule

`default_nettype wire
